@@ rtl/core/swsfr_pkg.sv @@
package swsfr_pkg;

   // Window geometry; sequence numbers run modulo twice the window
   localparam int WINDOW = 4;
   localparam int SEQ_W = 3;
   localparam int SLOT_W = $clog2(WINDOW);
   localparam int HANDLE_W = 32;
   localparam int DUP_W = 2;

   // Event kinds
   localparam logic [1:0] MODE_SEND = 2'd0;
   localparam logic [1:0] MODE_ACK = 2'd1;
   localparam logic [1:0] MODE_TIMEOUT = 2'd2;

   // Timer commands
   localparam logic [1:0] TIMER_NONE = 2'd0;
   localparam logic [1:0] TIMER_START = 2'd1;
   localparam logic [1:0] TIMER_STOP = 2'd2;
   localparam logic [1:0] TIMER_RESTART = 2'd3;

   // Duplicate count that fires a fast retransmit
   localparam logic [DUP_W-1:0] DUP_LIMIT = 2'd3;

   typedef struct packed {
      logic [1:0]          mode;
      logic [HANDLE_W-1:0] payload_handle;
      logic [SEQ_W-1:0]    ack_number;
      logic                ack_checksum_ok;
   } event_type;

   typedef struct packed {
      logic                accepted;
      logic                transmit_valid;
      logic [SEQ_W-1:0]    transmit_seq;
      logic [HANDLE_W-1:0] transmit_handle;
      logic [1:0]          timer_command;
      logic [SEQ_W-1:0]    window_base;
      logic                window_full;
   } result_type;

endpackage

@@ rtl/core/swsfr_in_stage.sv @@
module swsfr_in_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  swsfr_pkg::event_type in_event,
   output logic                held_valid,
   input  logic                held_taken,
   output swsfr_pkg::event_type held_event
);
   import swsfr_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   event_type event_ff;

   // Take a new transaction when empty or when the held one moves on
   assign in_ready = !valid_ff || held_taken;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until it is consumed
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         event_ff <= in_event;
      end
   end

   assign held_valid = valid_ff;
   assign held_event = event_ff;

endmodule

@@ rtl/core/swsfr_core.sv @@
module swsfr_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  swsfr_pkg::event_type ev,
   output swsfr_pkg::result_type res
);
   import swsfr_pkg::*;

   logic [SEQ_W-1:0]    base_seq_ff, base_seq_in;
   logic [SEQ_W-1:0]    next_seq_ff, next_seq_in;
   logic [DUP_W-1:0]    dup_count_ff, dup_count_in;
   logic [HANDLE_W-1:0] handle_store [WINDOW];

   logic [SEQ_W-1:0]    outstanding_now;
   logic [SEQ_W-1:0]    outstanding_after;
   logic                window_open;
   logic                store_write;
   logic [DUP_W-1:0]    dup_sum;
   logic [HANDLE_W-1:0] base_handle;

   assign outstanding_now = next_seq_ff - base_seq_ff;
   assign window_open = outstanding_now < SEQ_W'(WINDOW);
   assign dup_sum = dup_count_ff + DUP_W'(1);
   assign base_handle = handle_store[base_seq_ff[SLOT_W-1:0]];

   // Decode the event and work out the state update and result
   always_comb begin
      base_seq_in = base_seq_ff;
      next_seq_in = next_seq_ff;
      dup_count_in = dup_count_ff;
      store_write = 1'b0;
      res = '0;
      unique case (ev.mode)
         MODE_SEND: begin
            if (window_open) begin
               store_write = 1'b1;
               res.accepted = 1'b1;
               res.transmit_valid = 1'b1;
               res.transmit_seq = next_seq_ff;
               res.transmit_handle = ev.payload_handle;
               if (base_seq_ff == next_seq_ff) begin
                  res.timer_command = TIMER_START;
               end
               next_seq_in = next_seq_ff + SEQ_W'(1);
            end
         end
         MODE_ACK: begin
            if (ev.ack_checksum_ok) begin
               if (ev.ack_number == base_seq_ff && dup_sum == DUP_LIMIT) begin
                  // Third duplicate: fast retransmit, timer untouched
                  dup_count_in = '0;
                  res.transmit_valid = 1'b1;
                  res.transmit_seq = base_seq_ff;
                  res.transmit_handle = base_handle;
               end else begin
                  dup_count_in = (ev.ack_number == base_seq_ff) ? dup_sum : '0;
                  base_seq_in = ev.ack_number;
                  res.timer_command = (ev.ack_number == next_seq_ff) ?
                                      TIMER_STOP : TIMER_RESTART;
               end
            end
         end
         MODE_TIMEOUT: begin
            res.transmit_valid = 1'b1;
            res.transmit_seq = base_seq_ff;
            res.transmit_handle = base_handle;
            res.timer_command = TIMER_RESTART;
         end
         default: begin
         end
      endcase
      outstanding_after = next_seq_in - base_seq_in;
      res.window_base = base_seq_in;
      res.window_full = outstanding_after >= SEQ_W'(WINDOW);
   end

   // Advance the window state once per consumed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         base_seq_ff <= '0;
         next_seq_ff <= '0;
         dup_count_ff <= '0;
      end else if (step) begin
         base_seq_ff <= base_seq_in;
         next_seq_ff <= next_seq_in;
         dup_count_ff <= dup_count_in;
      end
   end

   // Store the handle in its window slot
   always_ff @(posedge clock) begin
      if (step && store_write) begin
         handle_store[next_seq_ff[SLOT_W-1:0]] <= ev.payload_handle;
      end
   end

   // The counter clears on the third duplicate, so it never rests there
   a_dup_below_limit: assert property (@(posedge clock) disable iff (reset)
      dup_count_ff != DUP_LIMIT)
      else $error("duplicate counter holds the retransmit limit");

   // An accepted send advances next_seq by one
   a_send_advances: assert property (@(posedge clock) disable iff (reset)
      (step && store_write) |=> next_seq_ff == $past(next_seq_ff) + SEQ_W'(1))
      else $error("accepted send did not advance next_seq");

   // Without a step the window state holds
   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !step |=> (base_seq_ff == $past(base_seq_ff) && next_seq_ff == $past(next_seq_ff)))
      else $error("window state moved without a transaction");

endmodule

@@ rtl/core/sliding_window_sender_fast_retransmit.sv @@
// Go-back-N sender control with fast retransmit.
// Input channel (req_*): one event per transaction; req_mode selects a send
// request, an acknowledgement or a timer expiry. Result channel (rsp_*): one
// result per event, in order, giving the send decision, any packet to
// (re)transmit with its stored handle, the timer command and the window
// base and full flag after the event.
// Path: an accepted event waits in the input register, then the decision
// logic loads the result register, from which the result transaction
// completes when rsp_ready is high.
// Throughput: one event per cycle while rsp_ready stays high, as the window
// update between the input register and the result register is combinational.
// Reset clears base, next sequence and duplicate count; stored handles are
// undefined until written, both channel registers come up empty.
// When the receiver stalls, the result register holds; one more event waits
// in the input register, and req_ready then drops until rsp_ready returns.
module sliding_window_sender_fast_retransmit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_mode,
   input  logic [swsfr_pkg::HANDLE_W-1:0]      req_payload_handle,
   input  logic [swsfr_pkg::SEQ_W-1:0]         req_ack_number,
   input  logic                                req_ack_checksum_ok,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_accepted,
   output logic                                rsp_transmit_valid,
   output logic [swsfr_pkg::SEQ_W-1:0]         rsp_transmit_seq,
   output logic [swsfr_pkg::HANDLE_W-1:0]      rsp_transmit_handle,
   output logic [1:0]                          rsp_timer_command,
   output logic [swsfr_pkg::SEQ_W-1:0]         rsp_window_base,
   output logic                                rsp_window_full
);
   import swsfr_pkg::*;

   event_type  req_event;
   event_type  held_event;
   logic       held_valid;
   logic       step;
   result_type result;
   result_type rsp_ff;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_event.mode = req_mode;
   assign req_event.payload_handle = req_payload_handle;
   assign req_event.ack_number = req_ack_number;
   assign req_event.ack_checksum_ok = req_ack_checksum_ok;

   swsfr_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_valid),
      .in_ready   (req_ready),
      .in_event   (req_event),
      .held_valid (held_valid),
      .held_taken (step),
      .held_event (held_event)
   );

   // Consume the held event whenever the result register can take it
   assign step = held_valid && (!rsp_valid_ff || rsp_ready);

   swsfr_core u_core (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .ev    (held_event),
      .res   (result)
   );

   assign rsp_valid_in = step || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Load the result register on each consumed transaction
   always_ff @(posedge clock) begin
      if (step) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = rsp_ff.accepted;
   assign rsp_transmit_valid = rsp_ff.transmit_valid;
   assign rsp_transmit_seq = rsp_ff.transmit_seq;
   assign rsp_transmit_handle = rsp_ff.transmit_handle;
   assign rsp_timer_command = rsp_ff.timer_command;
   assign rsp_window_base = rsp_ff.window_base;
   assign rsp_window_full = rsp_ff.window_full;

   // A stalled result with a waiting event must not lose the event
   a_no_drop: assert property (@(posedge clock) disable iff (reset)
      (held_valid && rsp_valid_ff && !rsp_ready) |=> held_valid)
      else $error("held event lost under stall");

   // An accepted send always transmits
   a_accept_tx: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_accepted) |-> rsp_transmit_valid)
      else $error("accepted send without transmit");

   // The timer only starts on an accepted send
   a_start_on_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_timer_command == TIMER_START) |-> rsp_accepted)
      else $error("timer start without accepted send");

endmodule
